/* design/nau_pkg.sv */
// Shared types, constants and table builder for the neural activation unit.
// No dependencies; imported by every module of the block but the checker.
package nau_pkg;

   localparam int DATA_W   = 16;
   localparam int FRAC_W   = 12;
   localparam int SEG_LOG2 = 8;
   localparam int SEGS     = 1 << SEG_LOG2;
   localparam int TANH_W   = FRAC_W + 2;
   localparam int ARG_W    = DATA_W + 1;
   localparam int FRC_W    = ARG_W - SEG_LOG2;
   localparam int SLOPE_W  = 10;
   localparam int DEN_W    = DATA_W;
   localparam int REM_W    = DATA_W + FRAC_W;
   localparam int QUO_W    = FRAC_W;
   localparam int SS_W     = FRAC_W + 1;
   localparam int SIG_W    = FRAC_W + 1;
   localparam int MAG_W    = FRAC_W + 1;

   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   typedef enum logic [2:0] {
      KIND_TANH      = 3'd0,
      KIND_SIGMOID   = 3'd1,
      KIND_RELU      = 3'd2,
      KIND_SOFTSIGN  = 3'd3,
      KIND_LINEAR    = 3'd4,
      KIND_GATED     = 3'd5,
      KIND_SOFTGATED = 3'd6
   } activation_kind_type;

   // Load strobes of pipeline stages two to six.
   typedef struct packed {
      logic ld2;
      logic ld3;
      logic ld4;
      logic ld5;
      logic ld6;
   } stage_load_type;

   typedef logic signed [TANH_W-1:0] tanh_tab_type [0:SEGS];

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [3:0]       qbits;
   } div_step_type;

   // Shift-subtract quotient, used only while the table is built.
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = (r << 1) | ((num >> i) & 64'd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'd1 << i);
         end
      end
      return q;
   endfunction

   // tanh points over [-8,8]: e^-h in Q30 by series, powers by rounded products.
   function automatic tanh_tab_type build_tanh_tab();
      tanh_tab_type    tab;
      longint unsigned h;
      longint unsigned sum;
      longint unsigned term;
      longint unsigned b;
      longint unsigned p;
      longint unsigned den;
      longint unsigned num;
      longint unsigned v;
      h    = 64'd1 << (35 - SEG_LOG2);
      sum  = Q30_ONE;
      term = Q30_ONE;
      p    = Q30_ONE;
      for (int n = 1; n < 48; n++) begin
         term = udiv64((term * h) >> 30, longint'(n));
         sum  = sum + term;
      end
      b = udiv64((64'd1 << 60) + (sum >> 1), sum);
      for (int m = 0; m <= SEGS / 2; m++) begin
         den = Q30_ONE + p;
         num = (Q30_ONE - p) << FRAC_W;
         v   = udiv64(num + (den >> 1), den);
         tab[SEGS/2 + m] = TANH_W'(v);
         tab[SEGS/2 - m] = -$signed(TANH_W'(v));
         p = (p * b + (64'd1 << 29)) >> 30;
      end
      return tab;
   endfunction

   // Four restoring steps; group picks quotient bits 4*group+3 down to 4*group.
   function automatic div_step_type div_4bits(input logic [REM_W-1:0] rem_in,
                                              input logic [DEN_W-1:0] den,
                                              input int unsigned group);
      div_step_type     res;
      logic [REM_W-1:0] trial;
      res.rem   = rem_in;
      res.qbits = '0;
      for (int j = 0; j < 4; j++) begin
         trial = REM_W'(den) << (group * 4 + 3 - j);
         if (res.rem >= trial) begin
            res.rem        = res.rem - trial;
            res.qbits[3-j] = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

/* design/nau_tanh_interp.sv */
// Two-stage tanh table read and linear interpolation.
// Depends on nau_pkg (table builder, stage load strobes).
module nau_tanh_interp import nau_pkg::*; (
   input  logic                       clock,
   input  stage_load_type             ld,
   input  logic [ARG_W-1:0]           arg_word,   // stage 1: offset argument, 13 fraction bits
   output logic signed [TANH_W-1:0]   tanh_out    // stage 3
);

   localparam tanh_tab_type TANH_TAB = build_tanh_tab();

   logic [SEG_LOG2-1:0]       idx;
   logic signed [TANH_W-1:0]  nxt;
   logic signed [TANH_W-1:0]  base_ff, base_in;
   logic [SLOPE_W-1:0]        slope_ff, slope_in;
   logic [FRC_W-1:0]          frac_ff;
   logic [SLOPE_W+FRC_W-1:0]  prod;
   logic signed [TANH_W-1:0]  tanh_ff, tanh_in;

   always_comb begin
      idx      = arg_word[ARG_W-1 -: SEG_LOG2];
      base_in  = TANH_TAB[{1'b0, idx}];
      nxt      = TANH_TAB[{1'b0, idx} + (SEG_LOG2+1)'(1)];
      slope_in = SLOPE_W'(nxt - base_in);
      prod     = SLOPE_W'(slope_ff) * (SLOPE_W+FRC_W)'(frac_ff)
                 + (SLOPE_W+FRC_W)'(1 << (FRC_W - 1));
      tanh_in  = base_ff + $signed({1'b0, prod[SLOPE_W+FRC_W-1 -: SLOPE_W]});
   end

   always_ff @(posedge clock) begin
      if (ld.ld2) begin
         base_ff  <= base_in;
         slope_ff <= slope_in;
         frac_ff  <= arg_word[FRC_W-1:0];
      end
      if (ld.ld3) begin
         tanh_ff <= tanh_in;
      end
   end

   assign tanh_out = tanh_ff;

endmodule

/* design/nau_softsign_div.sv */
// Softsign x/(1+|x|) through a four-stage restoring divider: operand setup, then four bits a stage.
// Depends on nau_pkg (divider step function, stage load strobes).
module nau_softsign_div import nau_pkg::*; (
   input  logic                      clock,
   input  stage_load_type            ld,
   input  logic signed [DATA_W-1:0]  x_value,   // stage 1
   output logic signed [SS_W-1:0]    ss_out     // stage 5
);

   logic [DATA_W-1:0] mag;
   logic [DEN_W-1:0]  den_in;
   logic [DEN_W-1:0]  den2_ff, den3_ff, den4_ff;
   logic              neg2_ff, neg3_ff, neg4_ff;
   logic [REM_W-1:0]  rem2_ff, rem3_ff, rem4_ff;
   logic [REM_W-1:0]  rem_in;
   logic [7:0]        q4_ff;
   logic [3:0]        q3_ff;
   div_step_type      st3, st4, st5;
   logic [QUO_W-1:0]  quo;
   logic signed [SS_W-1:0] ss_ff, ss_in;

   always_comb begin
      mag    = x_value[DATA_W-1] ? DATA_W'(~x_value + 1'b1) : DATA_W'(x_value);
      den_in = DEN_W'(1 << FRAC_W) + mag;
      rem_in = {mag, FRAC_W'(0)} + REM_W'(den_in >> 1);
      st3    = div_4bits(rem2_ff, den2_ff, 2);
      st4    = div_4bits(rem3_ff, den3_ff, 1);
      st5    = div_4bits(rem4_ff, den4_ff, 0);
      quo    = {q4_ff, st5.qbits};
      ss_in  = neg4_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   end

   always_ff @(posedge clock) begin
      if (ld.ld2) begin
         rem2_ff <= rem_in;
         den2_ff <= den_in;
         neg2_ff <= x_value[DATA_W-1];
      end
      if (ld.ld3) begin
         rem3_ff <= st3.rem;
         q3_ff   <= st3.qbits;
         den3_ff <= den2_ff;
         neg3_ff <= neg2_ff;
      end
      if (ld.ld4) begin
         rem4_ff <= st4.rem;
         q4_ff   <= {q3_ff, st4.qbits};
         den4_ff <= den3_ff;
         neg4_ff <= neg3_ff;
      end
      if (ld.ld5) begin
         ss_ff <= ss_in;
      end
   end

   assign ss_out = ss_ff;

endmodule

/* design/neural_activation_unit.sv */
// Neural activation unit: six-stage pipeline, one request a cycle when not stalled.
// Throughput: one request per cycle when the output is not stalled; each stage
// holds under back-pressure and bubbles close up, so a request is taken while a
// result waits at the output, as long as some stage is empty.
// Reset (synchronous, active high): clears all stage valid bits and sets the
// activation kind to linear pass-through.
module neural_activation_unit import nau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,     // [15:0] first_value, [31:16] second_value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,     // [15:0] activated_value
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_wr_data    // activation_kind
);

   localparam int NSTAGE = 6;

   // Configuration register: activation kind.
   activation_kind_type kind_ff, kind_in;

   // Stage valid bits and the free chain that steers loading.
   logic [NSTAGE:1]   valid_ff, valid_in;
   logic [NSTAGE+1:1] free;
   logic [NSTAGE:1]   load;
   stage_load_type    ld;

   // Carried payload.
   activation_kind_type kind1_ff, kind2_ff, kind3_ff, kind4_ff, kind5_ff;
   logic signed [DATA_W-1:0] x1_1_ff, x2_1_ff;
   logic signed [DATA_W-1:0] x1_2_ff, x1_3_ff, x1_4_ff, x1_5_ff;
   logic signed [TANH_W-1:0] t4_ff, t5_ff;
   logic [SIG_W-1:0]         sig4_ff, sig5_ff, sig_in;
   logic [TANH_W:0]          sig_sum;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;

   // Submodule results.
   logic signed [TANH_W-1:0] tanh_a, tanh_b;
   logic signed [SS_W-1:0]   ss_a, ss_b;
   logic [ARG_W-1:0]         arg_a, arg_b;

   // Product path of the gated kinds.
   logic signed [TANH_W-1:0] mul_a, mul_b;
   logic [MAG_W-1:0]         mag_a, mag_b;
   logic [2*MAG_W-1:0]       prod;
   logic [TANH_W-1:0]        prod_rnd;
   logic signed [DATA_W-1:0] mul_res;

   // ---- configuration ----
   always_comb begin
      kind_in = kind_ff;
      if (csr_wr_en) begin
         kind_in = activation_kind_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_LINEAR;
      end else begin
         kind_ff <= kind_in;
      end
   end

   // ---- pipeline control ----
   // A stage is free when empty or when the stage after it is free too;
   // load a stage when it is free and the stage before it holds a request.
   always_comb begin
      free[NSTAGE+1] = rsp_tready;
      for (int k = NSTAGE; k >= 1; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end
      load[1] = free[1] && req_tvalid;
      for (int k = 2; k <= NSTAGE; k++) begin
         load[k] = free[k] && valid_ff[k-1];
      end
      // Hold a stuck stage; drop a stage that drains with nothing behind it.
      for (int k = 1; k <= NSTAGE; k++) begin
         valid_in[k] = free[k] ? load[k] : valid_ff[k];
      end
      ld.ld2 = load[2];
      ld.ld3 = load[3];
      ld.ld4 = load[4];
      ld.ld5 = load[5];
      ld.ld6 = load[6];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = free[1];
   assign rsp_tvalid = valid_ff[NSTAGE];
   assign rsp_tdata  = rsp_data_ff;

   // ---- stage 1: capture the request ----
   always_ff @(posedge clock) begin
      if (load[1]) begin
         x1_1_ff  <= $signed(req_tdata[15:0]);
         x2_1_ff  <= $signed(req_tdata[31:16]);
         kind1_ff <= kind_ff;
      end
   end

   // Offset table arguments: the first value at full scale; the sigmoid
   // operand (the first value for plain sigmoid, else the second) is read
   // with one more fraction bit so the sigmoid gets tanh of half the value.
   assign arg_a = {~x1_1_ff[DATA_W-1], x1_1_ff[DATA_W-2:0], 1'b0};
   assign arg_b = (kind1_ff == KIND_SIGMOID) ? {~x1_1_ff[DATA_W-1], x1_1_ff}
                                             : {~x2_1_ff[DATA_W-1], x2_1_ff};

   nau_tanh_interp u_tanh_a (
      .clock    (clock),
      .ld       (ld),
      .arg_word (arg_a),
      .tanh_out (tanh_a)
   );

   nau_tanh_interp u_tanh_b (
      .clock    (clock),
      .ld       (ld),
      .arg_word (arg_b),
      .tanh_out (tanh_b)
   );

   nau_softsign_div u_ss_a (
      .clock   (clock),
      .ld      (ld),
      .x_value (x1_1_ff),
      .ss_out  (ss_a)
   );

   nau_softsign_div u_ss_b (
      .clock   (clock),
      .ld      (ld),
      .x_value (x2_1_ff),
      .ss_out  (ss_b)
   );

   // ---- stages 2 to 5: carry kind and operand, form the sigmoid ----
   always_comb begin
      sig_sum = {tanh_b[TANH_W-1], tanh_b} + (TANH_W+1)'((1 << FRAC_W) + 1);
      sig_in  = sig_sum[SIG_W:1];
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         kind2_ff <= kind1_ff;
         x1_2_ff  <= x1_1_ff;
      end
      if (load[3]) begin
         kind3_ff <= kind2_ff;
         x1_3_ff  <= x1_2_ff;
      end
      if (load[4]) begin
         kind4_ff <= kind3_ff;
         x1_4_ff  <= x1_3_ff;
         t4_ff    <= tanh_a;
         sig4_ff  <= sig_in;
      end
      if (load[5]) begin
         kind5_ff <= kind4_ff;
         x1_5_ff  <= x1_4_ff;
         t5_ff    <= t4_ff;
         sig5_ff  <= sig4_ff;
      end
   end

   // ---- stage 6: product of the gated kinds and the result select ----
   // Round the product magnitude half up, then apply the sign.
   always_comb begin
      if (kind5_ff == KIND_GATED) begin
         mul_a = t5_ff;
         mul_b = $signed({1'b0, sig5_ff});
      end else begin
         mul_a = TANH_W'(ss_a);
         mul_b = TANH_W'(ss_b);
      end
      mag_a    = mul_a[TANH_W-1] ? MAG_W'(-mul_a) : MAG_W'(mul_a);
      mag_b    = mul_b[TANH_W-1] ? MAG_W'(-mul_b) : MAG_W'(mul_b);
      prod     = (2*MAG_W)'(mag_a) * (2*MAG_W)'(mag_b) + (2*MAG_W)'(1 << (FRAC_W - 1));
      prod_rnd = prod[FRAC_W +: TANH_W];
      mul_res  = (mul_a[TANH_W-1] ^ mul_b[TANH_W-1]) ? -$signed(DATA_W'(prod_rnd))
                                                      :  $signed(DATA_W'(prod_rnd));
      case (kind5_ff)
         KIND_TANH:      rsp_data_in = DATA_W'(t5_ff);
         KIND_SIGMOID:   rsp_data_in = DATA_W'(sig5_ff);
         KIND_RELU:      rsp_data_in = x1_5_ff[DATA_W-1] ? '0 : x1_5_ff;
         KIND_SOFTSIGN:  rsp_data_in = DATA_W'(ss_a);
         KIND_LINEAR:    rsp_data_in = x1_5_ff;
         KIND_GATED,
         KIND_SOFTGATED: rsp_data_in = mul_res;
         default:        rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load[6]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* design/nau_checker.sv */
// Port-level checks of the neural activation unit, bound to the top level.
// Depends only on the top level's ports.
module nau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A fresh result after an empty output comes from an unstalled request.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 6))
      else $error("result without request six cycles earlier");

   // An empty output frees the whole pipeline.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (.*);

/* tb/sv/neural_activation_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for neural_activation_unit: random and edge-value requests
// in every activation kind, results checked against an in-bench predictor.
// Depends on nau_pkg and the neural_activation_unit RTL only.
module neural_activation_unit_tb;
   import nau_pkg::*;

   // Predicts activated_value for each accepted request and holds the
   // expectations until the matching result leaves the block.
   class activation_scoreboard;
      longint      tanh_points [0:256];
      logic [2:0]  kind;
      logic [15:0] pending_values [$];
      int          failures;

      function new();
         longint unsigned h, sum, term, b, p, den, num, v;
         h    = 64'd1 << 27;
         sum  = 64'd1 << 30;
         term = 64'd1 << 30;
         p    = 64'd1 << 30;
         for (int n = 1; n < 48; n++) begin
            term = ((term * h) >> 30) / n;
            sum  = sum + term;
         end
         b = ((64'd1 << 60) + sum / 2) / sum;
         for (int m = 0; m <= 128; m++) begin
            den = (64'd1 << 30) + p;
            num = ((64'd1 << 30) - p) << 12;
            v   = (num + den / 2) / den;
            tanh_points[128 + m] = longint'(v);
            tanh_points[128 - m] = -longint'(v);
            p = (p * b + (64'd1 << 29)) >> 30;
         end
         kind     = KIND_LINEAR;
         failures = 0;
      endfunction

      // tanh of v carrying fb fractional bits, result in Q4.12
      function longint tanh_of(longint v, int fb);
         longint lo, hi, u, idx, frac, d;
         int     sh;
         lo = -(longint'(8) << fb);
         hi = longint'(8) << fb;
         sh = fb - 4;
         if (v < lo) return tanh_points[0];
         if (v >= hi) return tanh_points[256];
         u    = v - lo;
         idx  = (u >> sh) & 255;
         frac = u & ((longint'(1) << sh) - 1);
         d    = tanh_points[idx + 1] - tanh_points[idx];
         return tanh_points[idx] + ((d * frac + (longint'(1) << (sh - 1))) >> sh);
      endfunction

      function longint sigmoid_of(longint x);
         return (4096 + tanh_of(x, 13) + 1) >> 1;
      endfunction

      function longint softsign_of(longint x);
         longint mag, r;
         mag = x < 0 ? -x : x;
         r   = ((mag << 12) + (4096 + mag) / 2) / (4096 + mag);
         return x < 0 ? -r : r;
      endfunction

      function longint q12_product(longint a, longint c);
         longint r;
         r = ((a < 0 ? -a : a) * (c < 0 ? -c : c) + 2048) >> 12;
         return ((a < 0) != (c < 0)) ? -r : r;
      endfunction

      function void note_request(logic signed [15:0] first_v, logic signed [15:0] second_v);
         longint x1, x2, r;
         x1 = first_v;
         x2 = second_v;
         case (kind)
            KIND_TANH:      r = tanh_of(x1, 12);
            KIND_SIGMOID:   r = sigmoid_of(x1);
            KIND_RELU:      r = x1 < 0 ? 0 : x1;
            KIND_SOFTSIGN:  r = softsign_of(x1);
            KIND_LINEAR:    r = x1;
            KIND_GATED:     r = q12_product(tanh_of(x1, 12), sigmoid_of(x2));
            KIND_SOFTGATED: r = q12_product(softsign_of(x1), softsign_of(x2));
            default:        r = 0;
         endcase
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         pending_values.push_back(16'(r));
      endfunction

      function void check_result(logic [15:0] actual);
         logic [15:0] want;
         if (pending_values.size() == 0) begin
            $error("activated_value: expected none, got %0d", $signed(actual));
            failures++;
            return;
         end
         want = pending_values.pop_front();
         if (want !== actual) begin
            $error("activated_value: expected %0d, got %0d", $signed(want), $signed(actual));
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // [15:0] first_value, [31:16] second_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] activated_value
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = '0;   // activation_kind

   activation_scoreboard results_board = new();
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   neural_activation_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // Receiver: stall at random on the falling edge, check on the rising edge.
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) results_board.check_result(rsp_tdata);

   // Hold one request on the bus until it is taken; idle first at random.
   task automatic send_request(logic [15:0] first_v, logic [15:0] second_v);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {second_v, first_v};
      do @(posedge clock); while (!req_tready);
      results_board.note_request(first_v, second_v);
   endtask

   // Drain the pipeline, then write the kind register while nothing is in flight.
   task automatic set_kind(logic [2:0] new_kind);
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (results_board.pending_values.size() == 0);
      repeat (10) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = new_kind;
      results_board.kind = new_kind;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Pick an edge value one time in four, else anything.
   function automatic logic [15:0] pick_value();
      logic [15:0] edges [8] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                                 16'h0001, 16'h1000, 16'hf000, 16'h7ff0};
      if ($urandom_range(3) == 0) return edges[$urandom_range(7)];
      return 16'($urandom);
   endfunction

   initial begin
      logic [15:0] corner [3] = '{16'h8000, 16'h7fff, 16'h0000};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: the reset kind first, then each kind with extreme operands.
      send_request(16'h8000, 16'h7fff);
      for (int k = 0; k < 8; k++) begin
         set_kind(3'(k));
         for (int i = 0; i < 3; i++) send_request(corner[i], corner[2 - i]);
      end

      // Random: cycle the kinds and the idle profiles; each kind comes twice, both times under the same profile.
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
            default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
         endcase
         set_kind(3'((ph * 3) % 8));
         for (int i = 0; i < 108; i++) send_request(pick_value(), pick_value());
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      wait (results_board.pending_values.size() == 0);
      repeat (20) @(posedge clock);
      if (results_board.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end
endmodule

/* neural_activation_unit.f */
design/nau_pkg.sv
design/nau_tanh_interp.sv
design/nau_softsign_div.sv
design/neural_activation_unit.sv
design/nau_checker.sv
tb/sv/neural_activation_unit_tb.sv
